// ===== design/tccw_pkg.sv =====
// Shared types, constants and helpers for the text console cell writer.
package tccw_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int IDX_W         = $clog2(CELL_COUNT);
    localparam int LAST_IDX      = CELL_COUNT - 1;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int ADDR_W  = 11;
    localparam int CELL_W  = 16;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

    typedef enum logic [2:0] {
        OP_PUTC   = 3'd0,
        OP_PUTAT  = 3'd1,
        OP_DEL    = 3'd2,
        OP_SETPOS = 3'd3,
        OP_CLR    = 3'd4,
        OP_READ   = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_FG        = 2'd0,
        CFG_BG        = 2'd1,
        CFG_CURSOR_EN = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [CHAR_W-1:0]  char_code;
        logic [ROW_W-1:0]   target_row;
        logic [COL_W-1:0]   target_col;
        logic [COLOR_W-1:0] cell_bg;
        logic [COLOR_W-1:0] cell_fg;
        logic               insert_mode;
    } t_item;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [ADDR_W-1:0] cursor_address;
        logic              cursor_shown;
        logic [CELL_W-1:0] cell_data;
    } t_result;

    typedef struct packed {
        logic [COLOR_W-1:0] bg;
        logic [COLOR_W-1:0] fg;
        logic [CHAR_W-1:0]  ch;
    } t_cell;

    localparam t_cell CELL_RESET = '{bg: 4'd0, fg: 4'd7, ch: CHAR_NUL};

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ADDR,
        S_EXEC,
        S_INS,
        S_DEL,
        S_DEL_LAST,
        S_CLR,
        S_RD,
        S_CUR,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_CALC,
        DP_PUT_AT,
        DP_RD_TGT,
        DP_RD_DATA,
        DP_INS_START,
        DP_INS_STEP,
        DP_DEL_START,
        DP_DEL_STEP,
        DP_DEL_LAST,
        DP_CLR_START,
        DP_CLR_STEP,
        DP_CURSOR,
        DP_RESULT
    } t_dp_op;

    typedef struct packed {
        t_opcode opcode;
        logic    is_nl;
        logic    is_bs;
        logic    tgt_ok;
        logic    cur_at_last;
        logic    ins_end;
        logic    del_end;
        logic    clr_end;
    } t_dp_status;

    function automatic logic [IDX_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [IDX_W-1:0] base;
        base = IDX_W'(row) * IDX_W'(SCREEN_WIDTH);
        return base + IDX_W'(col);
    endfunction

endpackage

// ===== design/tccw_ctrl.sv =====
// Sequencer for the console writer: one command at a time, drives the datapath.
module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output logic       o_busy,
    output t_dp_op     o_op
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = DP_NOP;
        o_busy  = 1'b1;
        unique case (r_state)
            S_INIT: begin
                // power-up fill of the screen memory
                o_op = DP_CLR_STEP;
                if (i_status.clr_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_op    = DP_CAPTURE;
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                o_op    = DP_CALC;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (i_status.opcode)
                    OP_PUTC: begin
                        if (i_status.is_nl || i_status.is_bs) begin
                            n_state = S_CUR;
                        end else begin
                            o_op    = DP_INS_START;
                            n_state = S_INS;
                        end
                    end
                    OP_PUTAT: begin
                        if (i_status.tgt_ok) begin
                            o_op = DP_PUT_AT;
                        end
                        n_state = S_DONE;
                    end
                    OP_DEL: begin
                        if (i_status.cur_at_last) begin
                            n_state = S_DONE;
                        end else begin
                            o_op    = DP_DEL_START;
                            n_state = S_DEL;
                        end
                    end
                    OP_SETPOS: begin
                        n_state = S_CUR;
                    end
                    OP_CLR: begin
                        o_op    = DP_CLR_START;
                        n_state = S_CLR;
                    end
                    OP_READ: begin
                        if (i_status.tgt_ok) begin
                            o_op    = DP_RD_TGT;
                            n_state = S_RD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_INS: begin
                o_op = DP_INS_STEP;
                if (i_status.ins_end) begin
                    n_state = S_CUR;
                end
            end
            S_DEL: begin
                o_op = DP_DEL_STEP;
                if (i_status.del_end) begin
                    n_state = S_DEL_LAST;
                end
            end
            S_DEL_LAST: begin
                o_op    = DP_DEL_LAST;
                n_state = S_DONE;
            end
            S_CLR: begin
                o_op = DP_CLR_STEP;
                if (i_status.clr_end) begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                o_op    = DP_RD_DATA;
                n_state = S_DONE;
            end
            S_CUR: begin
                o_op    = DP_CURSOR;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_op    = DP_RESULT;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/tccw_dp.sv =====
// Datapath: screen memory, cursor, shift pointer and result register.
module tccw_dp
    import tccw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_op             i_op,
    input  t_item              i_item,
    input  logic [COLOR_W-1:0] i_fg_color,
    input  logic [COLOR_W-1:0] i_bg_color,
    input  logic               i_cursor_en,
    output t_dp_status         o_status,
    output t_result            o_result,
    output logic               o_done
);

    t_cell m_cells [CELL_COUNT];

    t_item             r_item;
    logic [ROW_W-1:0]  r_cur_row;
    logic [COL_W-1:0]  r_cur_col;
    logic [IDX_W-1:0]  r_cur_idx;
    logic [IDX_W-1:0]  r_tgt_idx;
    logic              r_tgt_ok;
    logic [IDX_W-1:0]  r_ptr;
    logic              r_first;
    t_cell             r_carry;
    t_cell             r_fill;
    t_cell             r_rdata;
    logic [CELL_W-1:0] r_data;
    t_result           r_result;
    logic              r_done;

    logic [ROW_W-1:0]  n_cur_row;
    logic [COL_W-1:0]  n_cur_col;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_cell             mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;

    logic [IDX_W-1:0]  ptr_next;
    logic [IDX_W-1:0]  ptr_next2;
    logic              ins_end;
    logic              del_end;
    logic              clr_end;
    t_cell             put_cell;

    assign ptr_next  = r_ptr + IDX_W'(1);
    assign ptr_next2 = r_ptr + IDX_W'(2);
    // insert shift stops at once without insert mode, else at the first cell holding a NUL char, or at the last cell
    assign ins_end   = !r_item.insert_mode || (r_rdata.ch == CHAR_NUL)
                       || (r_ptr == IDX_W'(LAST_IDX));
    assign del_end   = (r_ptr == IDX_W'(LAST_IDX - 1));
    assign clr_end   = (r_ptr == IDX_W'(LAST_IDX));
    assign put_cell  = '{bg: i_bg_color, fg: i_fg_color, ch: r_item.char_code};

    always_comb begin
        o_status.opcode      = t_opcode'(r_item.opcode);
        o_status.is_nl       = (r_item.char_code == CHAR_NL);
        o_status.is_bs       = (r_item.char_code == CHAR_BS);
        o_status.tgt_ok      = r_tgt_ok;
        o_status.cur_at_last = (r_cur_idx == IDX_W'(LAST_IDX));
        o_status.ins_end     = ins_end;
        o_status.del_end     = del_end;
        o_status.clr_end     = clr_end;
    end

    // memory port select
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = r_fill;
        mem_raddr = r_ptr;
        unique case (i_op) inside
            DP_PUT_AT: begin
                mem_we    = 1'b1;
                mem_waddr = r_tgt_idx;
                mem_wdata = '{bg: r_item.cell_bg, fg: r_item.cell_fg, ch: r_item.char_code};
            end
            DP_RD_TGT: begin
                mem_raddr = r_tgt_idx;
            end
            DP_INS_START: begin
                mem_raddr = r_cur_idx;
            end
            DP_INS_STEP: begin
                // carry the old cell one place right, read the next one ahead
                mem_we    = 1'b1;
                mem_wdata = r_first ? put_cell : r_carry;
                mem_raddr = ins_end ? r_ptr : ptr_next;
            end
            DP_DEL_START: begin
                mem_raddr = r_cur_idx + IDX_W'(1);
            end
            DP_DEL_STEP: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
                mem_raddr = del_end ? r_ptr : ptr_next2;
            end
            DP_DEL_LAST: begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(LAST_IDX);
                mem_wdata = '{bg: i_bg_color, fg: i_fg_color, ch: CHAR_SPACE};
            end
            DP_CLR_STEP: begin
                mem_we = 1'b1;
            end
            DP_NOP, DP_CAPTURE, DP_CALC, DP_RD_DATA, DP_CLR_START, DP_CURSOR,
            DP_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_cells[mem_waddr] <= mem_wdata;
        end
        r_rdata <= m_cells[mem_raddr];
    end

    // cursor movement for put char and set position
    always_comb begin
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        if (t_opcode'(r_item.opcode) == OP_SETPOS) begin
            n_cur_row = (r_item.target_row < ROW_W'(SCREEN_HEIGHT))
                        ? r_item.target_row : ROW_W'(SCREEN_HEIGHT - 1);
            n_cur_col = (r_item.target_col < COL_W'(SCREEN_WIDTH))
                        ? r_item.target_col : COL_W'(SCREEN_WIDTH - 1);
        end else begin
            if (r_item.char_code == CHAR_NL) begin
                n_cur_row = r_cur_row + ROW_W'(1);
                n_cur_col = '0;
            end else if (r_item.char_code == CHAR_BS) begin
                if (r_cur_col != '0) begin
                    n_cur_col = r_cur_col - COL_W'(1);
                end
            end else begin
                n_cur_col = r_cur_col + COL_W'(1);
            end
            if (n_cur_col >= COL_W'(SCREEN_WIDTH)) begin
                n_cur_col = '0;
                n_cur_row = n_cur_row + ROW_W'(1);
            end
            if (n_cur_row >= ROW_W'(SCREEN_HEIGHT)) begin
                n_cur_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_ptr     <= '0;
            r_fill    <= CELL_RESET;
            r_done    <= 1'b0;
        end else begin
            r_done <= (i_op == DP_RESULT);
            case (i_op)
                DP_INS_START: r_ptr <= r_cur_idx;
                DP_INS_STEP: begin
                    if (!ins_end) begin
                        r_ptr <= ptr_next;
                    end
                end
                DP_DEL_START: r_ptr <= r_cur_idx;
                DP_DEL_STEP: begin
                    if (!del_end) begin
                        r_ptr <= ptr_next;
                    end
                end
                DP_CLR_START: begin
                    r_ptr     <= '0;
                    r_fill    <= '{bg: i_bg_color, fg: i_fg_color, ch: CHAR_NUL};
                    r_cur_row <= '0;
                    r_cur_col <= '0;
                end
                DP_CLR_STEP: begin
                    if (!clr_end) begin
                        r_ptr <= ptr_next;
                    end
                end
                DP_CURSOR: begin
                    r_cur_row <= n_cur_row;
                    r_cur_col <= n_cur_col;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            DP_CAPTURE: begin
                r_item <= i_item;
                r_data <= '0;
            end
            DP_CALC: begin
                r_cur_idx <= cell_index(r_cur_row, r_cur_col);
                r_tgt_idx <= cell_index(r_item.target_row, r_item.target_col);
                r_tgt_ok  <= (r_item.target_row < ROW_W'(SCREEN_HEIGHT))
                             && (r_item.target_col < COL_W'(SCREEN_WIDTH));
            end
            DP_INS_START: r_first <= 1'b1;
            DP_INS_STEP: begin
                r_first <= 1'b0;
                r_carry <= r_rdata;
            end
            DP_RD_DATA: r_data <= r_rdata;
            DP_RESULT: begin
                r_result.cursor_row     <= r_cur_row;
                r_result.cursor_col     <= r_cur_col;
                r_result.cursor_shown   <= i_cursor_en;
                r_result.cursor_address <= i_cursor_en
                                           ? ADDR_W'(cell_index(r_cur_row, r_cur_col))
                                           : '0;
                r_result.cell_data      <= r_data;
            end
            default: begin
            end
        endcase
    end

    assign o_result = r_result;
    assign o_done   = r_done;

`ifndef SYNTH
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held for more than one cycle");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= IDX_W'(LAST_IDX))
        else $error("shift pointer past the last cell");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_row < ROW_W'(SCREEN_HEIGHT)) && (r_cur_col < COL_W'(SCREEN_WIDTH)))
        else $error("cursor outside the screen");
`endif

endmodule

// ===== design/text_console_cell_writer.sv =====
// Commands run one at a time. Put char writes the cells moved by the insert shift (one cell
// without insert mode); delete moves the cells after the cursor; clear writes all
// SCREEN_WIDTH*SCREEN_HEIGHT cells. A new start is taken only while busy is low, the next one
// already in the strobe cycle; only busy stalls, the receiver cannot stall.
// Reset: synchronous; a fill of the screen memory follows, busy high meanwhile.
module text_console_cell_writer
    import tccw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_item              i_item,
    output logic               o_done,
    output t_result            o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [COLOR_W-1:0] r_fg_color;
    logic [COLOR_W-1:0] r_bg_color;
    logic               r_cursor_en;
    t_cfg_reg           reg_sel;
    t_dp_op             dp_op;
    t_dp_status         dp_status;

    assign pready  = 1'b1;
    assign reg_sel = t_cfg_reg'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_color  <= 4'd7;
            r_bg_color  <= '0;
            r_cursor_en <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                CFG_FG:        r_fg_color  <= pwdata[COLOR_W-1:0];
                CFG_BG:        r_bg_color  <= pwdata[COLOR_W-1:0];
                CFG_CURSOR_EN: r_cursor_en <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            CFG_FG:        prdata = PDATA_W'(r_fg_color);
            CFG_BG:        prdata = PDATA_W'(r_bg_color);
            CFG_CURSOR_EN: prdata = PDATA_W'(r_cursor_en);
            default:       prdata = '0;
        endcase
    end

    tccw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_busy   (busy),
        .o_op     (dp_op)
    );

    tccw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (dp_op),
        .i_item      (i_item),
        .i_fg_color  (r_fg_color),
        .i_bg_color  (r_bg_color),
        .i_cursor_en (r_cursor_en),
        .o_status    (dp_status),
        .o_result    (o_result),
        .o_done      (o_done)
    );

`ifndef SYNTH
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat shown while a command is still running");
`endif

endmodule
